### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// Next-cycle implication, checked on the rising clock edge.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/ptess_pkg.sv
`default_nettype none

package ptess_pkg;

   localparam int CMD_WIDTH = 3;
   localparam logic [CMD_WIDTH-1:0] CMD_LINE   = 3'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_CURVE  = 3'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_BEZIER = 3'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_CLOSE  = 3'd3;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 3'd4;

   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_ADDR_CURVE_RESOLUTION = 1'b0;

   localparam int RES_WIDTH = 7;
   localparam logic [RES_WIDTH-1:0] RES_RESET = 7'd20;

   typedef struct packed {
      logic acc_clear;
      logic acc_mac;
      logic div_load;
      logic div_step;
   } lane_ctrl_type;

endpackage

`default_nettype wire

### design/ptess_weights.sv
`default_nettype none

module ptess_weights #(
   parameter int RW = 7,
   parameter int WW = 24,
   parameter int DW = 22
) (
   input  logic                 clock,
   input  logic [RW-1:0]        index,
   input  logic [RW-1:0]        res,
   input  logic                 bezier,
   output logic signed [WW-1:0] weight [4],
   output logic [DW-1:0]        divisor,
   output logic [DW-1:0]        bias
);

   localparam int P2 = 2 * RW;
   localparam int P3 = 3 * RW;
   localparam int WC = P3 + 5;

   logic [RW-1:0] i1_ff, r1_ff, m1_ff;
   logic [P2-1:0] ii_ff, rr_ff, mm_ff;
   logic [P3-1:0] i3_ff, i2r_ff, ir2_ff, r3_ff, m3_ff, m2i_ff, mi2_ff;
   logic [RW-1:0] m_in;
   logic signed [WC-1:0] s_i3, s_i2r, s_ir2, s_r3, s_m3, s_m2i, s_mi2;
   logic signed [WC-1:0] w_in [4];

   assign m_in = res - index;

   assign s_i3  = $signed({{(WC-P3){1'b0}}, i3_ff});
   assign s_i2r = $signed({{(WC-P3){1'b0}}, i2r_ff});
   assign s_ir2 = $signed({{(WC-P3){1'b0}}, ir2_ff});
   assign s_r3  = $signed({{(WC-P3){1'b0}}, r3_ff});
   assign s_m3  = $signed({{(WC-P3){1'b0}}, m3_ff});
   assign s_m2i = $signed({{(WC-P3){1'b0}}, m2i_ff});
   assign s_mi2 = $signed({{(WC-P3){1'b0}}, mi2_ff});

   always_comb begin
      if (bezier) begin
         w_in[0] = WC'(s_m3 + s_m3);
         w_in[1] = WC'(s_m2i * 6);
         w_in[2] = WC'(s_mi2 * 6);
         w_in[3] = WC'(s_i3 + s_i3);
      end else begin
         w_in[0] = WC'(-s_i3 + s_i2r + s_i2r - s_ir2);
         w_in[1] = WC'(s_i3 * 3 - s_i2r * 5 + s_r3 + s_r3);
         w_in[2] = WC'(-(s_i3 * 3) + s_i2r * 4 + s_ir2);
         w_in[3] = WC'(s_i3 - s_i2r);
      end
   end

   always_ff @(posedge clock) begin
      i1_ff <= index;
      r1_ff <= res;
      m1_ff <= m_in;
      ii_ff <= P2'(index * index);
      rr_ff <= P2'(res * res);
      mm_ff <= P2'(m_in * m_in);
      i3_ff  <= P3'(ii_ff * i1_ff);
      i2r_ff <= P3'(ii_ff * r1_ff);
      ir2_ff <= P3'(rr_ff * i1_ff);
      r3_ff  <= P3'(rr_ff * r1_ff);
      m3_ff  <= P3'(mm_ff * m1_ff);
      m2i_ff <= P3'(mm_ff * i1_ff);
      mi2_ff <= P3'(ii_ff * m1_ff);
      for (int k = 0; k < 4; k++) begin
         weight[k] <= WW'(w_in[k]);
      end
      divisor <= DW'({r3_ff, 1'b0});
      bias    <= DW'(r3_ff);
   end

endmodule

`default_nettype wire

### design/ptess_lane.sv
`default_nettype none

module ptess_lane #(
   parameter int CW = 32,
   parameter int WW = 24,
   parameter int DW = 22,
   parameter int QB = 36
) (
   input  logic                     clock,
   input  ptess_pkg::lane_ctrl_type ctrl,
   input  logic signed [CW-1:0]     point,
   input  logic signed [WW-1:0]     weight,
   input  logic [DW-1:0]            divisor,
   input  logic [DW-1:0]            bias,
   output logic signed [CW-1:0]     result
);

   import ptess_pkg::*;

   localparam int RMW = DW + 1;
   localparam int SW  = QB + RMW;
   localparam int PW  = CW + WW;

   logic signed [SW-1:0] acc_ff;
   logic [RMW-1:0]       rem_ff;
   logic [QB-1:0]        quo_ff;
   logic                 neg_ff;

   logic signed [PW-1:0] product;
   logic [SW-1:0]        mag;
   logic [RMW-1:0]       shifted;
   logic [RMW:0]         diff;
   logic signed [QB:0]   quot;
   logic signed [QB:0]   qmax, qmin;

   assign product = point * weight;
   assign mag     = acc_ff[SW-1] ? (~acc_ff + {{(SW-DW){1'b0}}, divisor})
                                 : acc_ff;
   assign shifted = {rem_ff[RMW-2:0], quo_ff[QB-1]};
   assign diff    = {1'b0, shifted} - {2'b00, divisor};

   assign quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign qmax = $signed({{(QB-CW+2){1'b0}}, {(CW-1){1'b1}}});
   assign qmin = $signed({{(QB-CW+2){1'b1}}, {(CW-1){1'b0}}});

   always_comb begin
      if (quot > qmax) begin
         result = {1'b0, {(CW-1){1'b1}}};
      end else if (quot < qmin) begin
         result = {1'b1, {(CW-1){1'b0}}};
      end else begin
         result = quot[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.acc_clear) begin
         acc_ff <= $signed({{(SW-DW){1'b0}}, bias});
      end else if (ctrl.acc_mac) begin
         acc_ff <= acc_ff + $signed({{(SW-PW){product[PW-1]}}, product});
      end
      if (ctrl.div_load) begin
         neg_ff <= acc_ff[SW-1];
         rem_ff <= mag[SW-1:QB];
         quo_ff <= mag[QB-1:0];
      end else if (ctrl.div_step) begin
         rem_ff <= diff[RMW] ? shifted : diff[RMW-1:0];
         quo_ff <= {quo_ff[QB-2:0], ~diff[RMW]};
      end
   end

endmodule

`default_nettype wire

### design/path_curve_tessellator.sv
// Line and short-history commands give one vertex, close one only when the last vertex differs
// from the first; each is ready again once its vertex enters the output register.
// Curve and Bezier segments: r vertices, each from the three-stage weight pipeline, the
// four-term multiply-accumulate per lane and the restoring divider that retires one quotient bit per cycle.
// One command is in work at a time; the output register holds a vertex while the next works.
// Synchronous active-high reset clears the history, the vertex count and the resolution to 20.
`default_nettype none

module path_curve_tessellator #(
   parameter int MAX_RESOLUTION = 64,
   parameter int COORD_WIDTH    = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // end_x, end_y, end_z, ctrl1_x, ctrl1_y, ctrl1_z, ctrl2_x, ctrl2_y, ctrl2_z
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]   req_tdata,
   // cmd
   input  logic [ptess_pkg::CMD_WIDTH-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_x, out_y, out_z
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ptess_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ptess_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ptess_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   import ptess_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int RW  = $clog2(MAX_RESOLUTION + 1);
   localparam int DW  = 3 * RW + 1;
   localparam int WW  = DW + 2;
   localparam int QB  = CW + 4;
   localparam int QCW = $clog2(QB);
   localparam int RSP_TDATA_WIDTH = ((3*CW+7)/8)*8;

   typedef enum logic [2:0] {
      S_IDLE, S_WGT, S_CLR, S_MAC, S_LOAD, S_DIV, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [QCW-1:0] cnt_ff, cnt_in;
   logic [1:0]     k_ff, k_in;
   logic [RW-1:0]  i_ff, i_in, r_ff, r_in, r_eff;
   logic           bez_ff, bez_in, direct_ff, direct_in;
   logic [1:0]     count_ff, count_in;
   logic [RES_WIDTH-1:0] res_ff;

   logic signed [CW-1:0] hist_ff [3][3], hist_in [3][3];
   logic signed [CW-1:0] first_ff [3], first_in [3];
   logic signed [CW-1:0] p_ff [4][3], p_in [4][3];
   logic signed [CW-1:0] out_ff [3], out_in [3];
   logic                 last_ff, last_in, rvalid_ff, rvalid_in;

   logic signed [CW-1:0] end_pt [3], c1_pt [3], c2_pt [3], lane_res [3], vtx [3];
   logic signed [WW-1:0] weight [4];
   logic [DW-1:0]        divisor, bias;
   lane_ctrl_type        lctrl;
   logic req_fire, out_free, differs, csr_wr;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int a = 0; a < 3; a++) begin
         rsp_tdata[a*CW +: CW] = out_ff[a];
         end_pt[a] = req_tdata[a*CW +: CW];
         c1_pt[a]  = req_tdata[(a+3)*CW +: CW];
         c2_pt[a]  = req_tdata[(a+6)*CW +: CW];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == CSR_ADDR_CURVE_RESOLUTION);
   assign csr_prdata = (csr_paddr == CSR_ADDR_CURVE_RESOLUTION)
                       ? CSR_DATA_WIDTH'(res_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= RES_RESET;
      end else if (csr_wr) begin
         res_ff <= csr_pwdata[RES_WIDTH-1:0];
      end
   end

   always_comb begin
      if (res_ff == '0) begin
         r_eff = RW'(1);
      end else if (int'(res_ff) > MAX_RESOLUTION) begin
         r_eff = RW'(MAX_RESOLUTION);
      end else begin
         r_eff = RW'(res_ff);
      end
   end

   assign lctrl.acc_clear = (state_ff == S_CLR);
   assign lctrl.acc_mac   = (state_ff == S_MAC);
   assign lctrl.div_load  = (state_ff == S_LOAD);
   assign lctrl.div_step  = (state_ff == S_DIV);

   ptess_weights #(.RW(RW), .WW(WW), .DW(DW)) u_weights (
      .clock   (clock),
      .index   (i_ff),
      .res     (r_ff),
      .bezier  (bez_ff),
      .weight  (weight),
      .divisor (divisor),
      .bias    (bias)
   );

   for (genvar a = 0; a < 3; a++) begin : g_lane
      ptess_lane #(.CW(CW), .WW(WW), .DW(DW), .QB(QB)) u_lane (
         .clock   (clock),
         .ctrl    (lctrl),
         .point   (p_ff[k_ff][a]),
         .weight  (weight[k_ff]),
         .divisor (divisor),
         .bias    (bias),
         .result  (lane_res[a])
      );
   end

   assign differs = (first_ff[0] != hist_ff[0][0]) || (first_ff[1] != hist_ff[0][1])
                    || (first_ff[2] != hist_ff[0][2]);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      r_in      = r_ff;
      bez_in    = bez_ff;
      direct_in = direct_ff;
      count_in  = count_ff;
      hist_in   = hist_ff;
      first_in  = first_ff;
      p_in      = p_ff;
      out_in    = out_ff;
      last_in   = last_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      for (int a = 0; a < 3; a++) begin
         vtx[a] = direct_ff ? p_ff[3][a] : lane_res[a];
      end
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               r_in = r_eff;
               case (req_tuser)
                  CMD_LINE: begin
                     p_in[3] = end_pt;
                     direct_in = 1'b1;
                     state_in = S_EMIT;
                  end
                  CMD_CURVE: begin
                     p_in[3] = end_pt;
                     if (count_ff < 2'd2) begin
                        direct_in = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        p_in[0] = (count_ff == 2'd3) ? hist_ff[2] : hist_ff[1];
                        p_in[1] = hist_ff[1];
                        p_in[2] = hist_ff[0];
                        bez_in = 1'b0;
                        direct_in = 1'b0;
                        i_in = RW'(1);
                        cnt_in = '0;
                        state_in = S_WGT;
                     end
                  end
                  CMD_BEZIER: begin
                     p_in[3] = end_pt;
                     if (count_ff == 2'd0) begin
                        direct_in = 1'b1;
                        state_in = S_EMIT;
                     end else begin
                        p_in[0] = hist_ff[0];
                        p_in[1] = c1_pt;
                        p_in[2] = c2_pt;
                        bez_in = 1'b1;
                        direct_in = 1'b0;
                        i_in = RW'(1);
                        cnt_in = '0;
                        state_in = S_WGT;
                     end
                  end
                  CMD_CLOSE: begin
                     if (count_ff != 2'd0 && differs) begin
                        p_in[3] = first_ff;
                        direct_in = 1'b1;
                        state_in = S_EMIT;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                     for (int a = 0; a < 3; a++) begin
                        first_in[a] = '0;
                        for (int h = 0; h < 3; h++) begin
                           hist_in[h][a] = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WGT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == QCW'(2)) begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            k_in = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            k_in = k_ff + 1'b1;
            if (k_ff == 2'd3) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == QCW'(QB - 1)) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               out_in = vtx;
               last_in = direct_ff || (i_ff == r_ff);
               hist_in[2] = hist_ff[1];
               hist_in[1] = hist_ff[0];
               hist_in[0] = vtx;
               if (count_ff == 2'd0) begin
                  first_in = vtx;
               end
               if (count_ff != 2'd3) begin
                  count_in = count_ff + 1'b1;
               end
               if (direct_ff || (i_ff == r_ff)) begin
                  state_in = S_IDLE;
               end else begin
                  i_in = i_ff + 1'b1;
                  cnt_in = '0;
                  state_in = S_WGT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
         count_ff  <= '0;
         first_ff  <= '{default: '0};
         hist_ff   <= '{default: '{default: '0}};
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
         hist_ff   <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      r_ff      <= r_in;
      bez_ff    <= bez_in;
      direct_ff <= direct_in;
      p_ff      <= p_in;
      out_ff    <= out_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

### design/ptess_checker.sv
`default_nettype none
`include "assert_macros.svh"

module ptess_checker #(
   parameter int RSP_TDATA_WIDTH = 96
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [ptess_pkg::CMD_WIDTH-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata,
   input logic                            rsp_tlast
);

   import ptess_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_NEXT(a_clear_keeps_ready, clock, reset,
      req_tvalid && req_tready && req_tuser == CMD_CLEAR, req_tready)
   `ASSERT_NEXT(a_line_goes_busy, clock, reset,
      req_tvalid && req_tready && req_tuser == CMD_LINE, !req_tready)

endmodule

bind path_curve_tessellator ptess_checker #(.RSP_TDATA_WIDTH(RSP_TDATA_WIDTH)) u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
